// ===== rtl/iwcr_pkg.sv =====
// Shared types, constants and helpers of the isolated wall cell remover.
package iwcr_pkg;

  // Grid limits and derived counter widths
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int X_W        = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int Y_W        = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;

  // Fixed field widths
  localparam int KIND_W  = 3;
  localparam int COORD_W = 10;
  localparam int SIZE_W  = 11;
  localparam int SLOTS   = 4;

  // Stream data widths
  localparam int TDATA_IN_W  = 8;
  localparam int TDATA_OUT_W = 24;

  // Configuration port
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_KIND = 2'd2;

  // Cell kinds
  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t KIND_NONE = 3'd0;
  localparam kind_t KIND_WALL = 3'd2;

  // Row store entry: kind of the row above and of the row two above
  localparam int ENTRY_W = 2 * KIND_W;

  // One column of the 3x3 window
  typedef struct packed {
    kind_t top;
    kind_t mid;
    kind_t bot;
  } column_t;

  // Item on its way from the read stage to the window stage
  typedef struct packed {
    kind_t          kind;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic           first_col;
    logic           last_col;
    logic           last_row;
    logic           has_up1;
    logic           has_up2;
  } item_t;

  // Up to four results caused by one item
  typedef struct packed {
    logic [SLOTS-1:0]       mask;
    kind_t [SLOTS-1:0]      kind;
    logic [SLOTS-1:0]       cleared;
    logic [COORD_W-1:0]     x;
    logic [COORD_W-1:0]     xm;
    logic [COORD_W-1:0]     y;
    logic [COORD_W-1:0]     ym;
  } job_t;

  // A cell that does not block removal
  function automatic logic kind_ok(input kind_t k, input kind_t t);
    kind_ok = (k == KIND_NONE) || (k == t);
  endfunction

endpackage

// ===== rtl/iwcr_ram.sv =====
// Generic single-port-write, registered-read RAM.
module iwcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, held while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/iwcr_window.sv =====
// Window stage: row store write-back, 3x3 window shift and removal decisions.
module iwcr_window (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         restart,
  input  iwcr_pkg::kind_t              target_kind,
  input  logic                         load,
  input  iwcr_pkg::item_t              item_in,
  input  logic [iwcr_pkg::ENTRY_W-1:0] rd_data,
  input  logic                         job_free,
  output logic                         ready,
  output logic                         job_load,
  output iwcr_pkg::job_t               job,
  output logic                         wr_en,
  output logic [iwcr_pkg::X_W-1:0]     wr_addr,
  output logic [iwcr_pkg::ENTRY_W-1:0] wr_data
);

  logic              s1_valid;
  iwcr_pkg::item_t   s1_item;
  iwcr_pkg::column_t win_c1;
  iwcr_pkg::column_t win_c2;
  iwcr_pkg::column_t n0;
  iwcr_pkg::column_t n1;
  iwcr_pkg::column_t n2;
  iwcr_pkg::kind_t   up1;
  iwcr_pkg::kind_t   up2;
  logic [2:0]        ok0;
  logic [2:0]        ok1;
  logic [2:0]        ok2;
  logic              advance;

  assign advance  = s1_valid && job_free;
  assign ready    = !s1_valid || job_free;
  assign job_load = advance;

  // Hold the item while its read data is in the RAM output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ready) begin
      s1_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      s1_item <= item_in;
    end
  end

  // Rows above the grid read as none
  assign up1 = s1_item.has_up1 ? rd_data[iwcr_pkg::KIND_W-1:0] : iwcr_pkg::KIND_NONE;
  assign up2 = s1_item.has_up2 ? rd_data[iwcr_pkg::ENTRY_W-1:iwcr_pkg::KIND_W]
                               : iwcr_pkg::KIND_NONE;

  // Shift the window; a new row starts from an all-none window
  always_comb begin
    n0 = s1_item.first_col ? '0 : win_c1;
    n1 = s1_item.first_col ? '0 : win_c2;
    n2 = '{top: up2, mid: up1, bot: s1_item.kind};
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      win_c1 <= '0;
      win_c2 <= '0;
    end else if (advance) begin
      win_c1 <= n1;
      win_c2 <= n2;
    end
  end

  // Write back this row's kind and the row above at the same column
  assign wr_en   = advance;
  assign wr_addr = s1_item.x;
  assign wr_data = {up1, s1_item.kind};

  // Per-cell removal permission, order top/mid/bot in bits 2/1/0
  always_comb begin
    ok0 = {iwcr_pkg::kind_ok(n0.top, target_kind), iwcr_pkg::kind_ok(n0.mid, target_kind),
           iwcr_pkg::kind_ok(n0.bot, target_kind)};
    ok1 = {iwcr_pkg::kind_ok(n1.top, target_kind), iwcr_pkg::kind_ok(n1.mid, target_kind),
           iwcr_pkg::kind_ok(n1.bot, target_kind)};
    ok2 = {iwcr_pkg::kind_ok(n2.top, target_kind), iwcr_pkg::kind_ok(n2.mid, target_kind),
           iwcr_pkg::kind_ok(n2.bot, target_kind)};
  end

  // Build the results: inner cell, right edge, bottom row, bottom-right corner
  always_comb begin
    job.mask[0] = !s1_item.first_col && s1_item.has_up1;
    job.mask[1] = s1_item.last_col && s1_item.has_up1;
    job.mask[2] = !s1_item.first_col && s1_item.last_row;
    job.mask[3] = s1_item.last_col && s1_item.last_row;

    job.cleared[0] = (n1.mid == target_kind) && (&ok0) && (&ok1) && (&ok2);
    job.cleared[1] = (n2.mid == target_kind) && (&ok1) && (&ok2);
    job.cleared[2] = (n1.bot == target_kind) && (&ok0[1:0]) && (&ok1[1:0]) && (&ok2[1:0]);
    job.cleared[3] = (n2.bot == target_kind) && (&ok1[1:0]) && (&ok2[1:0]);

    job.kind[0] = job.cleared[0] ? iwcr_pkg::KIND_NONE : n1.mid;
    job.kind[1] = job.cleared[1] ? iwcr_pkg::KIND_NONE : n2.mid;
    job.kind[2] = job.cleared[2] ? iwcr_pkg::KIND_NONE : n1.bot;
    job.kind[3] = job.cleared[3] ? iwcr_pkg::KIND_NONE : n2.bot;

    job.x  = iwcr_pkg::COORD_W'(s1_item.x);
    job.xm = iwcr_pkg::COORD_W'(s1_item.x - iwcr_pkg::X_W'(1));
    job.y  = iwcr_pkg::COORD_W'(s1_item.y);
    job.ym = iwcr_pkg::COORD_W'(s1_item.y - iwcr_pkg::Y_W'(1));
  end

endmodule

// ===== rtl/iwcr_emit.sv =====
// Result queue: holds one item's results and sends them one per cycle while m_tready allows.
module iwcr_emit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             job_load,
  input  iwcr_pkg::job_t                   job_in,
  output logic                             job_free,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [iwcr_pkg::TDATA_OUT_W-1:0] m_tdata,
  output logic                             m_tuser,
  output logic                             m_tlast
);

  iwcr_pkg::job_t                 job;
  logic                           job_any;
  logic                           out_ok;
  logic                           pop;
  logic [iwcr_pkg::SLOTS-1:0]     sel;
  logic [iwcr_pkg::SLOTS-1:0]     remaining;
  iwcr_pkg::kind_t                sel_kind;
  logic                           sel_clr;
  logic [iwcr_pkg::COORD_W-1:0]   sel_x;
  logic [iwcr_pkg::COORD_W-1:0]   sel_y;

  assign job_any   = |job.mask;
  assign out_ok    = !m_tvalid || m_tready;
  assign pop       = job_any && out_ok;
  assign remaining = job.mask & ~sel;
  assign job_free  = !job_any || (pop && (remaining == '0));

  // Pick the lowest pending result
  always_comb begin
    sel      = '0;
    sel_kind = job.kind[0];
    sel_clr  = job.cleared[0];
    sel_x    = job.xm;
    sel_y    = job.ym;
    priority if (job.mask[0]) begin
      sel[0] = 1'b1;
    end else if (job.mask[1]) begin
      sel[1]   = 1'b1;
      sel_kind = job.kind[1];
      sel_clr  = job.cleared[1];
      sel_x    = job.x;
      sel_y    = job.ym;
    end else if (job.mask[2]) begin
      sel[2]   = 1'b1;
      sel_kind = job.kind[2];
      sel_clr  = job.cleared[2];
      sel_x    = job.xm;
      sel_y    = job.y;
    end else if (job.mask[3]) begin
      sel[3]   = 1'b1;
      sel_kind = job.kind[3];
      sel_clr  = job.cleared[3];
      sel_x    = job.x;
      sel_y    = job.y;
    end else begin
      sel = '0;
    end
  end

  // Load a new set of results or drop the one just sent
  always_ff @(posedge clk) begin
    if (rst) begin
      job.mask <= '0;
    end else if (job_load) begin
      job.mask <= job_in.mask;
    end else if (pop) begin
      job.mask <= remaining;
    end
    if (job_load) begin
      job.kind    <= job_in.kind;
      job.cleared <= job_in.cleared;
      job.x       <= job_in.x;
      job.xm      <= job_in.xm;
      job.y       <= job_in.y;
      job.ym      <= job_in.ym;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ok) begin
      m_tvalid <= job_any;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= {1'b0, sel_y, sel_x, sel_kind};
      m_tuser <= sel_clr;
      m_tlast <= (remaining == '0);
    end
  end

endmodule

// ===== rtl/isolated_wall_cell_remover_3x3_top.sv =====
// Top level of the isolated wall cell remover: config registers, raster counters, row store.
// Cells enter one per cycle in raster order while s_tready is high; each cell is
// read-modify-written in a MAX_WIDTH x 6-bit row store (one read and one write a cycle),
// reaches the 3x3 window in the cycle after it is accepted and sends its results through
// the result queue to the output register. Results leave one per cycle while m_tready
// allows: an item causes 0 results on the first row and in the first column, 1 elsewhere,
// 2 at a right edge or on the last row and up to 4 at the last cell, so the sustained
// rate is one item per cycle inside the grid, less where results outnumber items.
// Writing grid_width or grid_height restarts the frame at cell (0,0); the row store needs
// no clearing after reset.
module isolated_wall_cell_remover_3x3_top (
  input  logic                             clk,
  input  logic                             rst,
  // Input items
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [iwcr_pkg::TDATA_IN_W-1:0]  s_tdata,   // [2:0] cell_kind
  // Result items
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [iwcr_pkg::TDATA_OUT_W-1:0] m_tdata,   // [2:0] result_kind, [12:3] result_x,
                                                      // [22:13] result_y
  output logic                             m_tuser,   // [0] was_cleared
  output logic                             m_tlast,   // last_of_run
  // Configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [iwcr_pkg::PADDR_W-1:0]     paddr,
  input  logic [iwcr_pkg::PDATA_W-1:0]     pwdata,
  output logic [iwcr_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);

  localparam int WEXT_W = (iwcr_pkg::SIZE_W > iwcr_pkg::X_W + 1) ? iwcr_pkg::SIZE_W
                                                                 : iwcr_pkg::X_W + 1;
  localparam int HEXT_W = (iwcr_pkg::SIZE_W > iwcr_pkg::Y_W + 1) ? iwcr_pkg::SIZE_W
                                                                 : iwcr_pkg::Y_W + 1;

  logic [iwcr_pkg::SIZE_W-1:0]    grid_width;
  logic [iwcr_pkg::SIZE_W-1:0]    grid_height;
  iwcr_pkg::kind_t                target_kind;
  logic [iwcr_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           cfg_wr;
  logic                           restart;
  logic [WEXT_W-1:0]              gw_ext;
  logic [HEXT_W-1:0]              gh_ext;
  logic [iwcr_pkg::X_W-1:0]       w_last;
  logic [iwcr_pkg::Y_W-1:0]       h_last;
  logic [iwcr_pkg::X_W-1:0]       column_count;
  logic [iwcr_pkg::Y_W-1:0]       row_count;
  logic                           accept;
  logic                           win_ready;
  iwcr_pkg::item_t                item;
  logic [iwcr_pkg::ENTRY_W-1:0]   rd_data;
  logic                           wr_en;
  logic [iwcr_pkg::X_W-1:0]       wr_addr;
  logic [iwcr_pkg::ENTRY_W-1:0]   wr_data;
  logic                           job_load;
  logic                           job_free;
  iwcr_pkg::job_t                 job;

  assign pready  = 1'b1;
  assign reg_idx = paddr[iwcr_pkg::PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign restart = cfg_wr && ((reg_idx == iwcr_pkg::REG_GRID_WIDTH) ||
                              (reg_idx == iwcr_pkg::REG_GRID_HEIGHT));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= iwcr_pkg::SIZE_W'(1024);
      grid_height <= iwcr_pkg::SIZE_W'(1024);
      target_kind <= iwcr_pkg::KIND_WALL;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        iwcr_pkg::REG_GRID_WIDTH:  grid_width  <= pwdata[iwcr_pkg::SIZE_W-1:0];
        iwcr_pkg::REG_GRID_HEIGHT: grid_height <= pwdata[iwcr_pkg::SIZE_W-1:0];
        iwcr_pkg::REG_TARGET_KIND: target_kind <= pwdata[iwcr_pkg::KIND_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (reg_idx)
      iwcr_pkg::REG_GRID_WIDTH:  prdata = iwcr_pkg::PDATA_W'(grid_width);
      iwcr_pkg::REG_GRID_HEIGHT: prdata = iwcr_pkg::PDATA_W'(grid_height);
      iwcr_pkg::REG_TARGET_KIND: prdata = iwcr_pkg::PDATA_W'(target_kind);
      default:                   prdata = '0;
    endcase
  end

  // Last column and row of the grid, size saturated to [2, MAX]
  assign gw_ext = WEXT_W'(grid_width);
  assign gh_ext = HEXT_W'(grid_height);

  always_comb begin
    if (gw_ext < WEXT_W'(2)) begin
      w_last = iwcr_pkg::X_W'(1);
    end else if (gw_ext > WEXT_W'(iwcr_pkg::MAX_WIDTH)) begin
      w_last = iwcr_pkg::X_W'(iwcr_pkg::MAX_WIDTH - 1);
    end else begin
      w_last = iwcr_pkg::X_W'(gw_ext - WEXT_W'(1));
    end
    if (gh_ext < HEXT_W'(2)) begin
      h_last = iwcr_pkg::Y_W'(1);
    end else if (gh_ext > HEXT_W'(iwcr_pkg::MAX_HEIGHT)) begin
      h_last = iwcr_pkg::Y_W'(iwcr_pkg::MAX_HEIGHT - 1);
    end else begin
      h_last = iwcr_pkg::Y_W'(gh_ext - HEXT_W'(1));
    end
  end

  assign s_tready = win_ready;
  assign accept   = s_tvalid && s_tready;

  // Raster position of the next item
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (column_count == w_last) begin
        column_count <= '0;
        row_count    <= (row_count == h_last) ? '0 : row_count + iwcr_pkg::Y_W'(1);
      end else begin
        column_count <= column_count + iwcr_pkg::X_W'(1);
      end
    end
  end

  // Describe the accepted item for the window stage
  always_comb begin
    item.kind      = s_tdata[iwcr_pkg::KIND_W-1:0];
    item.x         = column_count;
    item.y         = row_count;
    item.first_col = (column_count == '0);
    item.last_col  = (column_count == w_last);
    item.last_row  = (row_count == h_last);
    item.has_up1   = (row_count != '0);
    item.has_up2   = (row_count > iwcr_pkg::Y_W'(1));
  end

  // Row store; consecutive items of one frame always address different columns
  iwcr_ram #(
    .WIDTH (iwcr_pkg::ENTRY_W),
    .DEPTH (iwcr_pkg::MAX_WIDTH)
  ) u_row_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (column_count),
    .rd_data (rd_data)
  );

  iwcr_window u_window (
    .clk         (clk),
    .rst         (rst),
    .restart     (restart),
    .target_kind (target_kind),
    .load        (accept),
    .item_in     (item),
    .rd_data     (rd_data),
    .job_free    (job_free),
    .ready       (win_ready),
    .job_load    (job_load),
    .job         (job),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data)
  );

  iwcr_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .job_load (job_load),
    .job_in   (job),
    .job_free (job_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== rtl/iwcr_checker.sv =====
// Port-level checks of the isolated wall cell remover, bound to the top level.
module iwcr_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [iwcr_pkg::TDATA_OUT_W-1:0] m_tdata,
  input logic                             m_tuser,
  input logic                             m_tlast
);

  // A stalled result holds
  a_hold : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("stalled result changed");

  // Reset leaves no result pending and the input open
  a_rst_out : assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result present after reset");

  a_rst_in : assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

  // A cleared cell always reads as none
  a_clr_none : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[iwcr_pkg::KIND_W-1:0] == iwcr_pkg::KIND_NONE)
    else $error("cleared cell with nonzero kind");

endmodule

bind isolated_wall_cell_remover_3x3_top iwcr_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ===== sim/tb_isolated_wall_cell_remover_3x3_top.sv =====
// Self-checking testbench for the 3x3 enclosed cell remover: directed and random raster streams, APB setup.
`timescale 1ns / 100ps

module tb_isolated_wall_cell_remover_3x3_top;

  localparam int LIMIT        = 300000;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [iwcr_pkg::REG_IDX_W-1:0] REG_SPARE = 2'd3;

  // One result cell as it leaves the block
  typedef struct packed {
    iwcr_pkg::kind_t              kind;
    logic [iwcr_pkg::COORD_W-1:0] x;
    logic [iwcr_pkg::COORD_W-1:0] y;
    logic                         cleared;
    logic                         last;
  } cell_result_t;

  // 3x3 neighborhood, entry r*3+c, row 0 on top, column 0 on the left
  typedef logic [8:0][iwcr_pkg::KIND_W-1:0] nbhd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                 s_tvalid = 1'b0;
  logic                                 s_tready;
  logic [iwcr_pkg::TDATA_IN_W-1:0]      s_tdata = '0;    // [2:0] cell_kind
  logic                                 m_tvalid;
  logic                                 m_tready = 1'b0;
  logic [iwcr_pkg::TDATA_OUT_W-1:0]     m_tdata;         // [2:0] result_kind, [12:3] result_x,
                                                         // [22:13] result_y
  logic                                 m_tuser;         // [0] was_cleared
  logic                                 m_tlast;         // last_of_run
  logic                                 psel = 1'b0;
  logic                                 penable = 1'b0;
  logic                                 pwrite = 1'b0;
  logic [iwcr_pkg::PADDR_W-1:0]         paddr = '0;
  logic [iwcr_pkg::PDATA_W-1:0]         pwdata = '0;
  logic [iwcr_pkg::PDATA_W-1:0]         prdata;
  logic                                 pready;

  // Register mirror, which is also the filter's setup
  logic [iwcr_pkg::SIZE_W-1:0] grid_w = 11'd1024;
  logic [iwcr_pkg::SIZE_W-1:0] grid_h = 11'd1024;
  iwcr_pkg::kind_t             target_k = iwcr_pkg::KIND_WALL;

  // Filter state
  iwcr_pkg::kind_t row_mem [2][iwcr_pkg::MAX_WIDTH];
  nbhd_t           win = '0;
  int unsigned     col_pos = 0;
  int unsigned     row_pos = 0;

  iwcr_pkg::kind_t pending_cells[$];
  cell_result_t    due_results[$];

  int   mismatches = 0;
  int   cycles = 0;
  bit   jitter = 1'b1;
  int   tx_hold = 0;
  int   rx_hold = 0;
  cell_result_t got, want;

  isolated_wall_cell_remover_3x3_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  task automatic flag(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Clamp a size register to the usable range
  function automatic int unsigned eff_size(input logic [iwcr_pkg::SIZE_W-1:0] v,
                                           input int unsigned maxv);
    if (v < 11'd2) return 2;
    if (int'(v) > int'(maxv)) return maxv;
    return int'(v);
  endfunction

  // Judge the center of a neighborhood
  function automatic cell_result_t filter_cell(input nbhd_t nb, input int unsigned cx,
                                               input int unsigned cy);
    cell_result_t r;
    logic hit;
    int i;
    hit = (nb[4] == target_k);
    for (i = 0; i < 9; i++)
      if (nb[i] != iwcr_pkg::KIND_NONE && nb[i] != target_k) hit = 1'b0;
    r.kind    = hit ? iwcr_pkg::KIND_NONE : nb[4];
    r.x       = iwcr_pkg::COORD_W'(cx);
    r.y       = iwcr_pkg::COORD_W'(cy);
    r.cleared = hit;
    r.last    = 1'b0;
    return r;
  endfunction

  // Move rows up by one, bottom row becomes none
  function automatic nbhd_t shift_up(input nbhd_t nb);
    nbhd_t d;
    int c;
    for (c = 0; c < 3; c++) begin
      d[c]     = nb[3 + c];
      d[3 + c] = nb[6 + c];
      d[6 + c] = iwcr_pkg::KIND_NONE;
    end
    return d;
  endfunction

  // Take one accepted cell: update the raster state and queue the results it causes
  task automatic advance_raster(input iwcr_pkg::kind_t k);
    int unsigned w, h, x, y, n, r;
    iwcr_pkg::kind_t up1, up2;
    nbhd_t ed_win;
    cell_result_t batch [4];
    w = eff_size(grid_w, iwcr_pkg::MAX_WIDTH);
    h = eff_size(grid_h, iwcr_pkg::MAX_HEIGHT);
    x = col_pos;
    y = row_pos;
    n = 0;
    if (x >= w) x = w - 1;
    if (y >= h) y = h - 1;

    up1 = (y >= 1) ? row_mem[(y - 1) % 2][x] : iwcr_pkg::KIND_NONE;
    up2 = (y >= 2) ? row_mem[y % 2][x] : iwcr_pkg::KIND_NONE;
    row_mem[y % 2][x] = k;

    // Slide the window one column left and load the new column
    if (x == 0) win = '0;
    for (r = 0; r < 3; r++) begin
      win[r * 3]     = win[r * 3 + 1];
      win[r * 3 + 1] = win[r * 3 + 2];
    end
    win[2] = up2;
    win[5] = up1;
    win[8] = k;

    // Window one column further right, nothing past the edge
    for (r = 0; r < 3; r++) begin
      ed_win[r * 3]     = win[r * 3 + 1];
      ed_win[r * 3 + 1] = win[r * 3 + 2];
      ed_win[r * 3 + 2] = iwcr_pkg::KIND_NONE;
    end

    if (y >= 1) begin
      if (x >= 1) batch[n++] = filter_cell(win, x - 1, y - 1);
      if (x == w - 1) batch[n++] = filter_cell(ed_win, w - 1, y - 1);
    end
    if (y == h - 1) begin
      if (x >= 1) batch[n++] = filter_cell(shift_up(win), x - 1, y);
      if (x == w - 1) batch[n++] = filter_cell(shift_up(ed_win), w - 1, y);
    end
    if (n > 0) batch[n - 1].last = 1'b1;
    for (r = 0; r < n; r++) due_results.push_back(batch[r]);

    // Advance the raster position, wrapping at the frame end
    x++;
    if (x >= w) begin
      x = 0;
      y++;
      if (y >= h) y = 0;
    end
    col_pos = x;
    row_pos = y;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(10, 24);
  endfunction

  // Drive input items from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_hold  <= 0;
    end else begin
      if (s_tvalid && s_tready) advance_raster(s_tdata[iwcr_pkg::KIND_W-1:0]);
      if (!s_tvalid || s_tready) begin
        if (tx_hold != 0) begin
          s_tvalid <= 1'b0;
          tx_hold  <= tx_hold - 1;
        end else if (pending_cells.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= iwcr_pkg::TDATA_IN_W'(pending_cells.pop_front());
          tx_hold  <= jitter ? pick_gap() : 0;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Check result items against the oldest expectation; stall the output at random
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_hold  <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.kind    = m_tdata[iwcr_pkg::KIND_W-1:0];
        got.x       = m_tdata[iwcr_pkg::KIND_W +: iwcr_pkg::COORD_W];
        got.y       = m_tdata[iwcr_pkg::KIND_W + iwcr_pkg::COORD_W +: iwcr_pkg::COORD_W];
        got.cleared = m_tuser;
        got.last    = m_tlast;
        if (due_results.size() == 0) begin
          flag($sformatf("unexpected result kind=%0d x=%0d y=%0d clr=%0b last=%0b",
                         got.kind, got.x, got.y, got.cleared, got.last));
        end else begin
          want = due_results.pop_front();
          if (got !== want)
            flag($sformatf("result %0d %0d %0d %0b %0b, want %0d %0d %0d %0b %0b",
                           got.kind, got.x, got.y, got.cleared, got.last,
                           want.kind, want.x, want.y, want.cleared, want.last));
        end
      end
      if (rx_hold != 0) begin
        m_tready <= 1'b0;
        rx_hold  <= rx_hold - 1;
      end else begin
        m_tready <= 1'b1;
        if (jitter && $urandom_range(0, 3) == 0) rx_hold <= pick_gap();
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb_isolated_wall_cell_remover_3x3_top NOT OK");
      $finish;
    end
  end

  // Restart the raster at cell (0,0)
  task automatic restart_frame();
    col_pos = 0;
    row_pos = 0;
    win     = '0;
  endtask

  task automatic write_reg(input logic [iwcr_pkg::REG_IDX_W-1:0] idx,
                           input logic [iwcr_pkg::PDATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      iwcr_pkg::REG_GRID_WIDTH: begin
        grid_w = val[iwcr_pkg::SIZE_W-1:0];
        restart_frame();
      end
      iwcr_pkg::REG_GRID_HEIGHT: begin
        grid_h = val[iwcr_pkg::SIZE_W-1:0];
        restart_frame();
      end
      iwcr_pkg::REG_TARGET_KIND: target_k = val[iwcr_pkg::KIND_W-1:0];
      default: ;
    endcase
  endtask

  task automatic read_reg(input logic [iwcr_pkg::REG_IDX_W-1:0] idx,
                          input logic [iwcr_pkg::PDATA_W-1:0] exp_val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== exp_val)
      flag($sformatf("register %0d reads %0h, want %0h", idx, prdata, exp_val));
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_all_regs();
    read_reg(iwcr_pkg::REG_GRID_WIDTH, iwcr_pkg::PDATA_W'(grid_w));
    read_reg(iwcr_pkg::REG_GRID_HEIGHT, iwcr_pkg::PDATA_W'(grid_h));
    read_reg(iwcr_pkg::REG_TARGET_KIND, iwcr_pkg::PDATA_W'(target_k));
  endtask

  // Wait until every item is taken and every result is back, then let the pipe drain
  task automatic settle();
    while (pending_cells.size() != 0 || s_tvalid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly target and none so that removal fires often
  function automatic iwcr_pkg::kind_t random_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return target_k;
    if (r < 80) return iwcr_pkg::KIND_NONE;
    if (r < 95) return iwcr_pkg::kind_t'($urandom_range(1, 4));
    return iwcr_pkg::kind_t'($urandom_range(5, 7));
  endfunction

  function automatic logic [iwcr_pkg::SIZE_W-1:0] random_size(input bit allow_huge);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return iwcr_pkg::SIZE_W'($urandom_range(0, 1));
    if (r < 70) return iwcr_pkg::SIZE_W'($urandom_range(2, 6));
    if (allow_huge && r >= 96) return iwcr_pkg::SIZE_W'($urandom_range(1025, 2047));
    return iwcr_pkg::SIZE_W'($urandom_range(7, 24));
  endfunction

  task automatic queue_random_cells(input int count);
    int i;
    for (i = 0; i < count; i++) pending_cells.push_back(random_kind());
  endtask

  initial begin
    int i, j, pick;
    logic [iwcr_pkg::PDATA_W-1:0] junk;
    iwcr_pkg::kind_t walls_frame [16];
    iwcr_pkg::kind_t none_frames [8];

    for (i = 0; i < 2; i++)
      for (j = 0; j < iwcr_pkg::MAX_WIDTH; j++) row_mem[i][j] = iwcr_pkg::KIND_NONE;

    // Enclosed walls, walls touching other kinds, and every odd kind
    walls_frame = '{3'd2, 3'd2, 3'd2, 3'd0,
                    3'd2, 3'd2, 3'd2, 3'd1,
                    3'd2, 3'd2, 3'd3, 3'd2,
                    3'd5, 3'd6, 3'd7, 3'd4};
    none_frames = '{3'd0, 3'd0, 3'd0, 3'd0,
                    3'd0, 3'd1, 3'd0, 3'd0};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    read_all_regs();

    // Directed: a 4x4 frame with walls as target
    write_reg(iwcr_pkg::REG_GRID_WIDTH, 32'd4);
    write_reg(iwcr_pkg::REG_GRID_HEIGHT, 32'd4);
    write_reg(iwcr_pkg::REG_TARGET_KIND, iwcr_pkg::PDATA_W'(iwcr_pkg::KIND_WALL));
    read_all_regs();
    for (i = 0; i < 16; i++) pending_cells.push_back(walls_frame[i]);
    settle();

    // Directed: undersized grid saturates to 2x2, target none, two frames back to back
    write_reg(iwcr_pkg::REG_TARGET_KIND, iwcr_pkg::PDATA_W'(iwcr_pkg::KIND_NONE));
    write_reg(iwcr_pkg::REG_GRID_WIDTH, 32'd1);
    write_reg(iwcr_pkg::REG_GRID_HEIGHT, 32'd0);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    read_all_regs();
    for (i = 0; i < 8; i++) pending_cells.push_back(none_frames[i]);
    settle();

    // Random phases; a size write lands mid-frame and restarts it
    for (i = 0; i < 9; i++) begin
      jitter = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(1, 7);
      junk = $urandom() & 32'hFFFF_F800;
      if (pick[0])
        write_reg(iwcr_pkg::REG_GRID_WIDTH, junk | iwcr_pkg::PDATA_W'(random_size(1'b0)));
      if (pick[1])
        write_reg(iwcr_pkg::REG_GRID_HEIGHT, junk | iwcr_pkg::PDATA_W'(random_size(1'b1)));
      if (pick[2])
        write_reg(iwcr_pkg::REG_TARGET_KIND, ($urandom_range(0, 99) < 85) ?
                  iwcr_pkg::PDATA_W'($urandom_range(0, 4)) :
                  iwcr_pkg::PDATA_W'($urandom_range(5, 7)));
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, $urandom());
      read_all_regs();
      queue_random_cells($urandom_range(12, 36));
      settle();
    end

    // Two columns, oversized height saturates
    jitter = 1'b0;
    write_reg(iwcr_pkg::REG_GRID_WIDTH, 32'd2);
    write_reg(iwcr_pkg::REG_GRID_HEIGHT, 32'd2047);
    write_reg(iwcr_pkg::REG_TARGET_KIND, iwcr_pkg::PDATA_W'(iwcr_pkg::KIND_WALL));
    read_all_regs();
    queue_random_cells(30);
    settle();

    if (mismatches == 0) begin
      $display("tb_isolated_wall_cell_remover_3x3_top OK");
    end else begin
      $display("tb_isolated_wall_cell_remover_3x3_top NOT OK");
    end
    $finish;
  end

endmodule
